/* hw/rtl/bwp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the bidirectional waveguide pipe.
// Used by the controller, the datapath and the top level; depends on nothing.

package bwp_pkg;

  // Width of the sample ports.
  localparam int IO_W = 24;

  // Configuration port geometry.
  localparam int CFG_DW  = 16;
  localparam int CFG_IW  = 3;
  localparam int DELAY_W = 10;

  // Coefficients are Q1.15 held as 17-bit signed factors.
  localparam int COEF_W = 17;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 17'sd32768;
  // Smallest low-pass coefficient, 0.02 in Q1.15.
  localparam logic signed [COEF_W-1:0] K_MIN    = 17'sd655;

  // Reset values of the configuration registers.
  localparam logic [DELAY_W-1:0] DELAY_RST = 10'd64;
  localparam logic [CFG_DW-1:0]  END_RST   = 16'd22938;
  localparam logic [CFG_DW-1:0]  DAMP_RST  = 16'd6554;
  localparam logic [CFG_DW-1:0]  DC_RST    = 16'd32604;
  localparam logic [CFG_DW-1:0]  SRC_RST   = 16'd31130;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    REG_DELAY = 3'd0,
    REG_END   = 3'd1,
    REG_DAMP  = 3'd2,
    REG_DC    = 3'd3,
    REG_SRC   = 3'd4
  } cfg_reg_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_HP  = 3'd0,
    MUL_END = 3'd1,
    MUL_RAD = 3'd2,
    MUL_SRC = 3'd3,
    MUL_LP  = 3'd4
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_ac;
    logic     ld_back;
    logic     ld_rad;
    logic     ld_fwd;
    logic     commit;
  } cmd_t;

endpackage

/* hw/rtl/bidirectional_waveguide_pipe.sv */
`timescale 1ns / 1ps
// Top level of the bidirectional waveguide pipe: controller plus datapath.
// Depends on bwp_pkg, bwp_ctrl, bwp_dp and bwp_ram.
//
//   Channel  Signals                                     Direction
//   input    in_valid_i, in_ready_o, injected_sample_i   sample beat in
//   output   out_valid_o, out_ready_i,
//            radiated_sample_o, returned_wave_o          result beat out
//   config   cfg_we_i, cfg_idx_i, cfg_data_i             register write
//
// The accepted sample passes through four steps of the single shared multiplier and
// then a write state that commits it; the high-pass product, the fifth of five,
// is formed in the cycle of acceptance. The next sample is taken in the cycle after
// the commit at the earliest, so only one sample is in flight at a time; its result
// beat appears in the cycle after the commit.
// The commit waits while the previous result is still held in the output register.
// After reset the rings read as zero through a fill tracker; there is no clearing pass.
// Reset is asynchronous and active low.

module bidirectional_waveguide_pipe #(
  parameter int LINE_DEPTH   = 1024,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [bwp_pkg::IO_W-1:0]  injected_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [bwp_pkg::IO_W-1:0]  radiated_sample_o,
  output logic signed [bwp_pkg::IO_W-1:0]  returned_wave_o,
  input  logic                             cfg_we_i,
  input  logic [bwp_pkg::CFG_IW-1:0]       cfg_idx_i,
  input  logic [bwp_pkg::CFG_DW-1:0]       cfg_data_i
);

  bwp_pkg::cmd_t cmd;

  // Sequencer.
  bwp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic, state and delay rings.
  bwp_dp #(
    .LINE_DEPTH   (LINE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .injected_sample_i (injected_sample_i),
    .radiated_sample_o (radiated_sample_o),
    .returned_wave_o   (returned_wave_o)
  );

endmodule

/* hw/rtl/bwp_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.

module bwp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bwp_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing controller of the waveguide pipe: steps one sample through the
// shared multiplier and owns the handshakes. Depends on bwp_pkg.

module bwp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bwp_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MEND = 6'b000010,
    S_MRAD = 6'b000100,
    S_MSRC = 6'b001000,
    S_MLP  = 6'b010000,
    S_WR   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state and per-state commands.
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.mul_sel   = bwp_pkg::MUL_HP;
    unique case (state_q)
      S_IDLE: begin
        // The high-pass product needs no input, so it is formed while waiting.
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bwp_pkg::MUL_HP;
        cmd_o.capture = accept;
        if (accept) begin
          state_d = S_MEND;
        end
      end
      S_MEND: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bwp_pkg::MUL_END;
        cmd_o.ld_ac   = 1'b1;
        state_d       = S_MRAD;
      end
      S_MRAD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bwp_pkg::MUL_RAD;
        cmd_o.ld_back = 1'b1;
        state_d       = S_MSRC;
      end
      S_MSRC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bwp_pkg::MUL_SRC;
        cmd_o.ld_rad  = 1'b1;
        state_d       = S_MLP;
      end
      S_MLP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bwp_pkg::MUL_LP;
        cmd_o.ld_fwd  = 1'b1;
        state_d       = S_WR;
      end
      S_WR: begin
        // Wait here while the previous result still sits in the output register.
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output beat valid flag.
  assign out_valid_d = cmd_o.commit || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Only one sample is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("bwp_ctrl: input taken while a sample is in flight");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("bwp_ctrl: pending result overwritten");

  // Every commit presents a result beat in the next cycle.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("bwp_ctrl: commit without an output beat");
`endif

endmodule

/* hw/rtl/bwp_dp.sv */
`timescale 1ns / 1ps
// Datapath of the waveguide pipe: configuration registers, filter state, the
// shared multiplier and the two delay rings. Depends on bwp_pkg and bwp_ram.

module bwp_dp #(
  parameter int LINE_DEPTH   = 1024,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bwp_pkg::cmd_t                    cmd_i,
  input  logic                             cfg_we_i,
  input  logic [bwp_pkg::CFG_IW-1:0]       cfg_idx_i,
  input  logic [bwp_pkg::CFG_DW-1:0]       cfg_data_i,
  input  logic signed [bwp_pkg::IO_W-1:0]  injected_sample_i,
  output logic signed [bwp_pkg::IO_W-1:0]  radiated_sample_o,
  output logic signed [bwp_pkg::IO_W-1:0]  returned_wave_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int IOW  = bwp_pkg::IO_W;
  localparam int DW   = bwp_pkg::DELAY_W;
  localparam int CWC  = bwp_pkg::COEF_W;
  localparam int AW   = $clog2(LINE_DEPTH);
  localparam int CW   = ((AW > DW) ? AW : DW) + 1;
  localparam int WW   = ((SW > IOW) ? SW : IOW) + 4;
  localparam int OW   = SW + 1;
  localparam int PW   = OW + CWC;
  localparam int RW   = PW - 15;

  localparam logic signed [WW-1:0] SW_MAX = {{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [WW-1:0] SW_MIN = {{(WW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [WW-1:0] IO_MAX = {{(WW-IOW+1){1'b0}}, {(IOW-1){1'b1}}};
  localparam logic signed [WW-1:0] IO_MIN = {{(WW-IOW+1){1'b1}}, {(IOW-1){1'b0}}};
  localparam logic signed [PW-1:0] RND_HALF = PW'(16384);
  localparam logic [CW-1:0] DLY_MAX   = CW'(LINE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(LINE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_DEPTH - 1);

  function automatic logic signed [WW-1:0] ext_sw(input logic signed [SW-1:0] v);
    return {{(WW-SW){v[SW-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [WW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SW_MAX) begin
      r = SW_MAX[SW-1:0];
    end else if (v < SW_MIN) begin
      r = SW_MIN[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [IOW-1:0] sat_io(input logic signed [WW-1:0] v);
    logic signed [IOW-1:0] r;
    if (v > IO_MAX) begin
      r = IO_MAX[IOW-1:0];
    end else if (v < IO_MIN) begin
      r = IO_MIN[IOW-1:0];
    end else begin
      r = v[IOW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [DW-1:0]                 delay_q;
  logic [bwp_pkg::CFG_DW-1:0]    end_q, damp_q, dc_q, src_q;
  logic [DW-1:0]                 delay_eff;
  logic [bwp_pkg::CFG_DW-1:0]    dc_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= bwp_pkg::DELAY_RST;
      end_q   <= bwp_pkg::END_RST;
      damp_q  <= bwp_pkg::DAMP_RST;
      dc_q    <= bwp_pkg::DC_RST;
      src_q   <= bwp_pkg::SRC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bwp_pkg::REG_DELAY: delay_q <= cfg_data_i[DW-1:0];
        bwp_pkg::REG_END:   end_q   <= cfg_data_i;
        bwp_pkg::REG_DAMP:  damp_q  <= cfg_data_i;
        bwp_pkg::REG_DC:    dc_q    <= cfg_data_i;
        bwp_pkg::REG_SRC:   src_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The idle cycle already uses the delay and the DC coefficient, so a write
  // in that same cycle is forwarded.
  assign delay_eff = (cfg_we_i && (cfg_idx_i == bwp_pkg::REG_DELAY)) ?
                     cfg_data_i[DW-1:0] : delay_q;
  assign dc_eff    = (cfg_we_i && (cfg_idx_i == bwp_pkg::REG_DC)) ? cfg_data_i : dc_q;

  // Filter state and per-sample working registers.
  logic signed [SW-1:0] prev_q, hps_q, lp_q;
  logic signed [SW-1:0] x_q, ac_q, back_q, rad_q, fwd_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [AW-1:0]        wp_q, wp_next;
  logic                 wrapped_q;
  logic                 rd_ok_q, rd_ok;
  logic signed [IOW-1:0] rad_out_q, ret_out_q;

  // Read address one delay behind the write pointer, with the delay clamped.
  logic [CW-1:0] wp_c, dly_c, rd_c;
  logic [AW-1:0] rd_addr;

  always_comb begin
    wp_c  = CW'(wp_q);
    dly_c = CW'(delay_eff);
    if (dly_c == '0) begin
      dly_c = CW'(1);
    end else if (dly_c > DLY_MAX) begin
      dly_c = DLY_MAX;
    end
    if (wp_c < dly_c) begin
      rd_c = wp_c + DEPTH_C - dly_c;
    end else begin
      rd_c = wp_c - dly_c;
    end
  end

  assign rd_addr = rd_c[AW-1:0];
  assign wp_next = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;

  // Slots 1..wp have been written since reset until the pointer first wraps;
  // any other slot still reads as zero.
  assign rd_ok = wrapped_q || ((rd_addr != '0) && (rd_addr <= wp_q));

  // Delay rings.
  logic [SW-1:0]        fwd_rd, bwd_rd;
  logic signed [SW-1:0] at_out, at_src, lp_new;

  bwp_ram #(.WIDTH(SW), .DEPTH(LINE_DEPTH)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (wp_next),
    .wdata_i (fwd_q),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_addr),
    .rdata_o (fwd_rd)
  );

  bwp_ram #(.WIDTH(SW), .DEPTH(LINE_DEPTH)) u_bwd_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (wp_next),
    .wdata_i (lp_new),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_addr),
    .rdata_o (bwd_rd)
  );

  assign at_out = rd_ok_q ? $signed(fwd_rd) : '0;
  assign at_src = rd_ok_q ? $signed(bwd_rd) : '0;

  // Coefficients as signed Q1.15 factors.
  logic signed [CWC-1:0] end_c, rad_c, src_c, dc_c, kd, k_c;

  assign end_c = $signed({1'b0, end_q});
  assign src_c = $signed({1'b0, src_q});
  assign dc_c  = $signed({1'b0, dc_eff});
  assign rad_c = bwp_pkg::COEF_ONE - end_c;
  assign kd    = bwp_pkg::COEF_ONE - $signed({1'b0, damp_q});
  assign k_c   = (kd < bwp_pkg::K_MIN) ? bwp_pkg::K_MIN : kd;

  // Shared multiplier operand selection.
  logic signed [OW-1:0]  mul_a;
  logic signed [CWC-1:0] mul_c;
  logic signed [WW-1:0]  lp_diff;

  assign lp_diff = ext_sw(back_q) - ext_sw(lp_q);

  always_comb begin
    case (cmd_i.mul_sel)
      bwp_pkg::MUL_HP: begin
        mul_a = {hps_q[SW-1], hps_q};
        mul_c = dc_c;
      end
      bwp_pkg::MUL_END: begin
        mul_a = {at_out[SW-1], at_out};
        mul_c = end_c;
      end
      bwp_pkg::MUL_RAD: begin
        mul_a = {at_out[SW-1], at_out};
        mul_c = rad_c;
      end
      bwp_pkg::MUL_SRC: begin
        mul_a = {at_src[SW-1], at_src};
        mul_c = src_c;
      end
      bwp_pkg::MUL_LP: begin
        mul_a = lp_diff[OW-1:0];
        mul_c = k_c;
      end
      default: begin
        mul_a = '0;
        mul_c = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_c;

  // Round the registered product to nearest, ties upward, back to Q8.16.
  logic signed [PW-1:0] rsum;
  logic signed [WW-1:0] rnd_w;

  assign rsum  = prod_q + RND_HALF;
  assign rnd_w = {{(WW-RW){rsum[PW-1]}}, rsum[PW-1:15]};

  assign lp_new = sat_sw(ext_sw(lp_q) + rnd_w);

  // Product register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Per-sample working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= sat_sw({{(WW-IOW){injected_sample_i[IOW-1]}}, injected_sample_i});
    end
    if (cmd_i.ld_ac) begin
      ac_q <= sat_sw(ext_sw(x_q) - ext_sw(prev_q) + rnd_w);
    end
    if (cmd_i.ld_back) begin
      back_q <= sat_sw(-rnd_w);
    end
    if (cmd_i.ld_rad) begin
      rad_q <= sat_sw(rnd_w);
    end
    if (cmd_i.ld_fwd) begin
      fwd_q <= sat_sw(ext_sw(ac_q) + rnd_w);
    end
    if (cmd_i.commit) begin
      rad_out_q <= sat_io(ext_sw(rad_q));
      ret_out_q <= sat_io(ext_sw(at_src));
    end
  end

  // Filter state, write pointer and fill tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      hps_q     <= '0;
      lp_q      <= '0;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        rd_ok_q <= rd_ok;
      end
      if (cmd_i.commit) begin
        prev_q <= x_q;
        hps_q  <= ac_q;
        lp_q   <= lp_new;
        wp_q   <= wp_next;
        if (wp_next == '0) begin
          wrapped_q <= 1'b1;
        end
      end
    end
  end

  assign radiated_sample_o = rad_out_q;
  assign returned_wave_o   = ret_out_q;

`ifndef NO_ASSERTIONS
  // The read tap never lands on the slot that was written last.
  a_tap_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> (rd_addr != wp_q))
    else $error("bwp_dp: read tap sits on the last written slot");

  // Once every slot has been written, it stays so.
  a_wrapped_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("bwp_dp: fill flag cleared");

  // The fill flag rises exactly when the pointer comes back to slot zero.
  a_wrap_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wrapped_q) |-> (wp_q == '0))
    else $error("bwp_dp: fill flag set away from slot zero");
`endif

endmodule
